FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the text console RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tcw_pkg.sv
// Package of the text console writer: field widths, command and operation codes,
// character constants and the operation record passed from front to back.
// Depends on nothing.
package tcw_pkg;

  localparam int BYTE_W    = 8;
  localparam int CELL_W    = 2 * BYTE_W;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 2;

  // Commands carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CURSOR = 3'd0,
    CMD_PUT_POS    = 3'd1,
    CMD_BACKSPACE  = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_READ       = 3'd4
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 2'd1;

  localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RST = 8'd7;
  localparam logic [BYTE_W-1:0] ERROR_ATTR_RST   = 8'd244;

  // Characters with a meaning of their own.
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ERROR   = 8'h45;

  // A tab writes this many spaces.
  localparam int TAB_SPACES = 4;
  localparam int TAB_CNT_W  = $clog2(TAB_SPACES);
  localparam logic [TAB_CNT_W-1:0] TAB_LAST = TAB_CNT_W'(TAB_SPACES - 1);

  // Operation classes decided by the front end.
  typedef enum logic [3:0] {
    K_NOP       = 4'd0,
    K_PUT_CHAR  = 4'd1,
    K_NEWLINE   = 4'd2,
    K_RETURN    = 4'd3,
    K_TAB       = 4'd4,
    K_ERR_MARK  = 4'd5,
    K_BACKSPACE = 4'd6,
    K_CLEAR     = 4'd7,
    K_READ      = 4'd8,
    K_READ_BAD  = 4'd9
  } op_kind_t;

  // One classified operation, with the attribute already resolved.
  typedef struct packed {
    op_kind_t           kind;
    logic               at_pos;
    logic               bad;
    logic [BYTE_W-1:0]  ch;
    logic [BYTE_W-1:0]  at;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } op_t;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

FILE: hw/rtl/tcw_queue.sv
// Short operation queue between the front end and the back end.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcw_pkg::op_t   push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tcw_pkg::op_t   pop_data
);

  localparam logic [tcw_pkg::QCNT_W-1:0] FULL_COUNT = tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH);
  localparam logic [tcw_pkg::QPTR_W-1:0] LAST_PTR   = tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1);

  tcw_pkg::op_t                  entries [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]    count;

  assign full     = (count == FULL_COUNT);
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + tcw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - tcw_pkg::QCNT_W'(1);
      end
    end
  end

  // The front end must never push into a full queue.
  `ASSERT_RST(a_no_overflow, clk, rst, push |-> (count != FULL_COUNT), "queue overflow")

endmodule

FILE: hw/rtl/tcw_front.sv
// Front end of the text console writer: configuration registers, input
// handshake and classification of each item into an operation for the queue.
// Depends on tcw_pkg.
module tcw_front #(
  parameter int COLS,
  parameter int ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]       command,
  input  logic [tcw_pkg::BYTE_W-1:0]      char_code,
  input  logic [tcw_pkg::BYTE_W-1:0]      attr,
  input  logic [tcw_pkg::COL_W-1:0]       col,
  input  logic [tcw_pkg::ROW_W-1:0]       row,
  input  logic                            init_busy,
  input  logic                            q_full,
  output logic                            q_push,
  output tcw_pkg::op_t                    q_data
);

  logic [tcw_pkg::BYTE_W-1:0] default_attr;
  logic [tcw_pkg::BYTE_W-1:0] error_attr;
  logic [tcw_pkg::BYTE_W-1:0] attr_eff;
  logic                       bad;
  tcw_pkg::op_kind_t          char_kind;

  // Configuration registers; the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= tcw_pkg::DEFAULT_ATTR_RST;
      error_attr   <= tcw_pkg::ERROR_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tcw_pkg::CFG_DEFAULT_ATTR) begin
        default_attr <= cfg_data;
      end else if (cfg_index == tcw_pkg::CFG_ERROR_ATTR) begin
        error_attr <= cfg_data;
      end
    end
  end

  // Items wait while the store is being cleared after reset or the queue is full.
  assign in_stall = init_busy || q_full;
  assign q_push   = in_valid && !in_stall;

  assign attr_eff = (attr == '0) ? default_attr : attr;
  assign bad      = (int'(col) >= COLS) || (int'(row) >= ROWS);

  // Control characters get their own operation class.
  always_comb begin
    case (char_code)
      tcw_pkg::CH_NEWLINE: char_kind = tcw_pkg::K_NEWLINE;
      tcw_pkg::CH_RETURN:  char_kind = tcw_pkg::K_RETURN;
      tcw_pkg::CH_TAB:     char_kind = tcw_pkg::K_TAB;
      default:             char_kind = tcw_pkg::K_PUT_CHAR;
    endcase
  end

  // Build the operation record for the back end.
  always_comb begin
    q_data.kind   = tcw_pkg::K_NOP;
    q_data.at_pos = 1'b0;
    q_data.bad    = 1'b0;
    q_data.ch     = char_code;
    q_data.at     = attr_eff;
    q_data.col    = col;
    q_data.row    = row;
    case (tcw_pkg::cmd_t'(command))
      tcw_pkg::CMD_PUT_CURSOR: begin
        q_data.kind = char_kind;
      end
      tcw_pkg::CMD_PUT_POS: begin
        if (bad) begin
          q_data.kind = tcw_pkg::K_ERR_MARK;
          q_data.bad  = 1'b1;
          q_data.ch   = tcw_pkg::CH_ERROR;
          q_data.at   = error_attr;
        end else begin
          q_data.kind   = char_kind;
          q_data.at_pos = 1'b1;
        end
      end
      tcw_pkg::CMD_BACKSPACE: begin
        q_data.kind = tcw_pkg::K_BACKSPACE;
        q_data.at   = default_attr;
      end
      tcw_pkg::CMD_CLEAR: begin
        q_data.kind = tcw_pkg::K_CLEAR;
        q_data.at   = default_attr;
      end
      tcw_pkg::CMD_READ: begin
        q_data.kind = bad ? tcw_pkg::K_READ_BAD : tcw_pkg::K_READ;
        q_data.bad  = bad;
      end
      default: begin
        q_data.kind = tcw_pkg::K_NOP;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tcw_back.sv
// Back end of the text console writer: the cell store, the cursor, the
// sequencer for writes, sweeps and scrolls, and the result register.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_back #(
  parameter int COLS,
  parameter int ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tcw_pkg::op_t                  q_data,
  output logic                          q_pop,
  output logic                          init_busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
  output logic                          scrolled,
  output logic                          bad_position,
  output logic [tcw_pkg::BYTE_W-1:0]    read_char,
  output logic [tcw_pkg::BYTE_W-1:0]    read_attr
);

  localparam int NCELLS = COLS * ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int IW     = $clog2(NCELLS + 1);
  localparam int CW     = $clog2(COLS);
  localparam int RW     = $clog2(ROWS + 1);

  localparam logic [AW-1:0] LAST_CELL  = AW'(NCELLS - 1);
  localparam logic [IW-1:0] FIRST_COPY = IW'(COLS);
  localparam logic [IW-1:0] END_COPY   = IW'(NCELLS);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
  localparam logic [RW-1:0] ROWS_END   = RW'(ROWS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_CLEAR  = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_ZERO   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                          state;
  tcw_pkg::op_t                    op;
  logic [CW-1:0]                   pcol;
  logic [RW-1:0]                   prow;
  logic [tcw_pkg::TAB_CNT_W-1:0]   cnt;
  logic [IW-1:0]                   sidx;
  logic [AW-1:0]                   widx;
  logic                            pend;
  logic                            scrolled_r;

  logic [tcw_pkg::CELL_W-1:0]      mem [NCELLS];
  logic [tcw_pkg::CELL_W-1:0]      rdata;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;

  logic [CW-1:0]                   adv_col;
  logic [RW-1:0]                   adv_row;
  logic [CW-1:0]                   bs_col;
  logic [RW-1:0]                   bs_row;
  logic [RW-1:0]                   nl_row;
  logic [AW-1:0]                   pos_addr;
  logic [AW-1:0]                   bs_addr;
  logic [AW-1:0]                   op_addr;
  logic                            out_free;
  logic                            out_load;
  logic                            pop_now;

  // Cursor one cell forward, one cell back, and one row down.
  always_comb begin
    if (pcol == LAST_COL) begin
      adv_col = '0;
      adv_row = prow + RW'(1);
    end else begin
      adv_col = pcol + CW'(1);
      adv_row = prow;
    end
  end

  always_comb begin
    if (pcol != '0) begin
      bs_col = pcol - CW'(1);
      bs_row = prow;
    end else if (prow != '0) begin
      bs_col = LAST_COL;
      bs_row = prow - RW'(1);
    end else begin
      bs_col = '0;
      bs_row = '0;
    end
  end

  assign nl_row   = prow + RW'(1);
  assign pos_addr = AW'(prow) * AW'(COLS) + AW'(pcol);
  assign bs_addr  = (pos_addr == '0) ? '0 : pos_addr - AW'(1);
  assign op_addr  = AW'(op.row) * AW'(COLS) + AW'(op.col);

  // Handshake with the queue and the result register.
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_DONE) && out_free;
  assign pop_now   = q_valid && ((state == S_IDLE) || out_load);
  assign q_pop     = pop_now;
  assign init_busy = (state == S_INIT);

  // Store port selection for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = widx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = op_addr;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        case (op.kind)
          tcw_pkg::K_PUT_CHAR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
            mem_wdata = {op.at, op.ch};
          end
          tcw_pkg::K_TAB: begin
            mem_we    = (prow != ROWS_END);
            mem_waddr = pos_addr;
            mem_wdata = {op.at, tcw_pkg::CH_SPACE};
          end
          tcw_pkg::K_ERR_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = LAST_CELL;
            mem_wdata = {op.at, op.ch};
          end
          tcw_pkg::K_BACKSPACE: begin
            mem_we    = 1'b1;
            mem_waddr = bs_addr;
            mem_wdata = {op.at, tcw_pkg::CH_SPACE};
          end
          tcw_pkg::K_READ: begin
            mem_re = 1'b1;
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {op.at, tcw_pkg::CH_SPACE};
      end
      S_SCROLL: begin
        mem_re    = (sidx != END_COPY);
        mem_raddr = sidx[AW-1:0];
        mem_we    = pend;
        mem_wdata = rdata;
      end
      S_ZERO: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Cell store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Sequencer and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      pcol       <= '0;
      prow       <= '0;
      cnt        <= '0;
      sidx       <= '0;
      widx       <= '0;
      pend       <= 1'b0;
      scrolled_r <= 1'b0;
    end else if (pop_now) begin
      op         <= q_data;
      cnt        <= '0;
      sidx       <= FIRST_COPY;
      widx       <= '0;
      pend       <= 1'b0;
      scrolled_r <= 1'b0;
      state      <= S_EXEC;
      if (q_data.at_pos) begin
        pcol <= CW'(q_data.col);
        prow <= RW'(q_data.row);
      end
    end else begin
      case (state)
        S_INIT: begin
          widx <= widx + AW'(1);
          if (widx == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          state <= S_IDLE;
        end
        S_EXEC: begin
          case (op.kind)
            tcw_pkg::K_PUT_CHAR: begin
              pcol  <= adv_col;
              prow  <= adv_row;
              state <= (adv_row == ROWS_END) ? S_SCROLL : S_DONE;
            end
            tcw_pkg::K_NEWLINE: begin
              pcol  <= '0;
              prow  <= nl_row;
              state <= (nl_row == ROWS_END) ? S_SCROLL : S_DONE;
            end
            tcw_pkg::K_RETURN: begin
              pcol  <= '0;
              state <= S_DONE;
            end
            tcw_pkg::K_TAB: begin
              pcol <= adv_col;
              prow <= adv_row;
              cnt  <= cnt + tcw_pkg::TAB_CNT_W'(1);
              if (cnt == tcw_pkg::TAB_LAST) begin
                state <= (adv_row == ROWS_END) ? S_SCROLL : S_DONE;
              end
            end
            tcw_pkg::K_BACKSPACE: begin
              pcol  <= bs_col;
              prow  <= bs_row;
              state <= S_DONE;
            end
            tcw_pkg::K_CLEAR: begin
              state <= S_CLEAR;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_CLEAR: begin
          widx <= widx + AW'(1);
          if (widx == LAST_CELL) begin
            pcol  <= '0;
            prow  <= '0;
            state <= S_DONE;
          end
        end
        S_SCROLL: begin
          // Each cell is read here and written one row up in the next cycle, from the registered read data.
          if (sidx != END_COPY) begin
            sidx <= sidx + IW'(1);
          end
          pend <= (sidx != END_COPY);
          if (pend) begin
            widx <= widx + AW'(1);
          end
          if ((sidx == END_COPY) && !pend) begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          widx <= widx + AW'(1);
          if (widx == LAST_CELL) begin
            prow       <= LAST_ROW;
            scrolled_r <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_col   <= tcw_pkg::COL_W'(pcol);
      cursor_row   <= tcw_pkg::ROW_W'(prow);
      scrolled     <= scrolled_r;
      bad_position <= op.bad;
      if (op.kind == tcw_pkg::K_READ) begin
        read_char <= rdata[tcw_pkg::BYTE_W-1:0];
        read_attr <= rdata[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
      end else begin
        read_char <= '0;
        read_attr <= '0;
      end
    end
  end

  // Between items the cursor is always on the screen.
  `ASSERT_RST(a_cursor_on_screen, clk, rst, (state == S_IDLE) |-> (prow < ROWS_END), "cursor off screen")
  // The last zeroing step of a scroll puts the cursor on the last row and flags it.
  `ASSERT_RST(a_scroll_end, clk, rst, ((state == S_ZERO) && (widx == LAST_CELL)) |=> ((state == S_DONE) && scrolled_r && (prow == LAST_ROW)), "scroll end wrong")
  // Nothing is written to the store while the sequencer waits for work.
  `ASSERT_ALWAYS(a_idle_no_write, clk, (state == S_IDLE) |-> !mem_we, "store written while idle")

endmodule

FILE: hw/rtl/text_console_writer.sv
// Text console writer: a COLS by ROWS store of character and attribute cells
// with a cursor, driven by put, put-at-position, backspace, clear and read
// commands, one result per item. After reset the store is swept to zero with
// in_stall high; configuration writes are taken throughout. For a character,
// control code, backspace or read the back-end sequencer takes the operation
// from the queue, executes it and starts the result; a tab's four spaces go
// through the single store write port one at a time, and a clear sweeps every
// cell. A step that scrolls moves every cell up one row through the one read
// and one write port of the store, then zeroes the last row. A two-entry queue
// and the result register let new items be taken while a result waits.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]       command,
  input  logic [tcw_pkg::BYTE_W-1:0]      char_code,
  input  logic [tcw_pkg::BYTE_W-1:0]      attr,
  input  logic [tcw_pkg::COL_W-1:0]       col,
  input  logic [tcw_pkg::ROW_W-1:0]       row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcw_pkg::COL_W-1:0]       cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]       cursor_row,
  output logic                            scrolled,
  output logic                            bad_position,
  output logic [tcw_pkg::BYTE_W-1:0]      read_char,
  output logic [tcw_pkg::BYTE_W-1:0]      read_attr
);

  logic          init_busy;
  logic          q_full;
  logic          q_push;
  tcw_pkg::op_t  q_push_data;
  logic          q_pop;
  logic          q_valid;
  tcw_pkg::op_t  q_pop_data;

  // Front end: configuration and classification.
  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .char_code (char_code),
    .attr      (attr),
    .col       (col),
    .row       (row),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  // Operation queue.
  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  // Back end: store, cursor and results.
  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_pop_data),
    .q_pop        (q_pop),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .scrolled     (scrolled),
    .bad_position (bad_position),
    .read_char    (read_char),
    .read_attr    (read_attr)
  );

endmodule

FILE: tb/tb_text_console_writer.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: a directed table, then random commands.
// Every result is compared with a cycle-free model of the screen store and cursor.
// Depends on tcw_pkg and text_console_writer.
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int NCELLS      = COLS * ROWS;
  localparam int DIR_N       = 26;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 356;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 40;

  // Command and register codes that the block has no use for.
  localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  // Cursor and read-back status returned for each item.
  typedef struct packed {
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic              scr;
    logic              bad;
    logic [BYTE_W-1:0] rd_char;
    logic [BYTE_W-1:0] rd_attr;
  } status_t;

  // One directed item, with its status typed in where it is obvious.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] at;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic              typed;
    status_t           want;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_N] = '{
    // Freshly reset store reads back as zero.
    '{CMD_READ,       8'h00, 8'h00, 7'd0,   5'd0,  1'b1,
      '{7'd0, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUT_CURSOR, 8'h41, 8'h00, 7'd0,   5'd0,  1'b1,
      '{7'd1, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd0,   5'd0,  1'b1,
      '{7'd1, 5'd0, 1'b0, 1'b0, 8'h41, DEFAULT_ATTR_RST}},
    '{CMD_PUT_CURSOR, 8'hFF, 8'hFF, 7'd127, 5'd31, 1'b0, '0},
    '{CMD_PUT_CURSOR, 8'h00, 8'h01, 7'd0,   5'd0,  1'b0, '0},
    // Control codes: tab, carriage return, newline.
    '{CMD_PUT_CURSOR, CH_TAB,     8'h00, 7'd0, 5'd0, 1'b1,
      '{7'd7, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUT_CURSOR, CH_RETURN,  8'h00, 7'd0, 5'd0, 1'b1,
      '{7'd0, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUT_CURSOR, CH_NEWLINE, 8'h00, 7'd0, 5'd0, 1'b1,
      '{7'd0, 5'd1, 1'b0, 1'b0, 8'h00, 8'h00}},
    // Backspace across a row boundary blanks the last cell of the row above.
    '{CMD_BACKSPACE,  8'h00, 8'h00, 7'd0,   5'd0,  1'b1,
      '{7'd79, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd79,  5'd0,  1'b1,
      '{7'd79, 5'd0, 1'b0, 1'b0, CH_SPACE, DEFAULT_ATTR_RST}},
    // Off-screen put leaves an error marker in the last cell.
    '{CMD_PUT_POS,    8'h78, 8'h01, 7'd127, 5'd31, 1'b1,
      '{7'd79, 5'd0, 1'b0, 1'b1, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd79,  5'd24, 1'b1,
      '{7'd79, 5'd0, 1'b0, 1'b0, CH_ERROR, ERROR_ATTR_RST}},
    '{CMD_READ,       8'h00, 8'h00, 7'd80,  5'd0,  1'b1,
      '{7'd79, 5'd0, 1'b0, 1'b1, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd0,   5'd25, 1'b1,
      '{7'd79, 5'd0, 1'b0, 1'b1, 8'h00, 8'h00}},
    // Writing the last cell scrolls the screen.
    '{CMD_PUT_POS,    8'h5A, 8'h00, 7'd79,  5'd24, 1'b1,
      '{7'd0, 5'd24, 1'b1, 1'b0, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd79,  5'd23, 1'b1,
      '{7'd0, 5'd24, 1'b0, 1'b0, 8'h5A, DEFAULT_ATTR_RST}},
    '{CMD_READ,       8'h00, 8'h00, 7'd79,  5'd24, 1'b1,
      '{7'd0, 5'd24, 1'b0, 1'b0, 8'h00, 8'h00}},
    // Tab two cells from the end drops its last two spaces and scrolls.
    '{CMD_PUT_POS,    CH_TAB, 8'h80, 7'd78, 5'd24, 1'b1,
      '{7'd2, 5'd24, 1'b1, 1'b0, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd79,  5'd23, 1'b0, '0},
    '{CMD_PUT_POS,    CH_NEWLINE, 8'h00, 7'd0, 5'd24, 1'b1,
      '{7'd0, 5'd24, 1'b1, 1'b0, 8'h00, 8'h00}},
    '{CMD_PUT_POS,    CH_RETURN,  8'h00, 7'd5, 5'd3,  1'b1,
      '{7'd0, 5'd3, 1'b0, 1'b0, 8'h00, 8'h00}},
    // Unused commands only report the cursor.
    '{CMD_SPARE_LO,   8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1,
      '{7'd0, 5'd3, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_SPARE_HI,   8'hFF, 8'hFF, 7'd127, 5'd31, 1'b1,
      '{7'd0, 5'd3, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_CLEAR,      8'h00, 8'h00, 7'd0,   5'd0,  1'b1,
      '{7'd0, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}},
    '{CMD_READ,       8'h00, 8'h00, 7'd10,  5'd10, 1'b1,
      '{7'd0, 5'd0, 1'b0, 1'b0, CH_SPACE, DEFAULT_ATTR_RST}},
    // Backspace at the home cell stays there.
    '{CMD_BACKSPACE,  8'h00, 8'h00, 7'd0,   5'd0,  1'b1,
      '{7'd0, 5'd0, 1'b0, 1'b0, 8'h00, 8'h00}}
  };

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command    = '0;
  logic [BYTE_W-1:0]    char_code  = '0;
  logic [BYTE_W-1:0]    attr       = '0;
  logic [COL_W-1:0]     col        = '0;
  logic [ROW_W-1:0]     row        = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [COL_W-1:0]     cursor_col;
  logic [ROW_W-1:0]     cursor_row;
  logic                 scrolled;
  logic                 bad_position;
  logic [BYTE_W-1:0]    read_char;
  logic [BYTE_W-1:0]    read_attr;

  // Mirror of the screen store, the cursor and the two attribute registers.
  logic [CELL_W-1:0] shadow_cells [NCELLS];
  int unsigned       shadow_cursor;
  logic [BYTE_W-1:0] shadow_dflt;
  logic [BYTE_W-1:0] shadow_err;

  status_t     pending_status [$];
  status_t     oldest;
  int          err_count   = 0;
  int          result_count = 0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;
  int          stall_tick  = 0;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .char_code   (char_code),
    .attr        (attr),
    .col         (col),
    .row         (row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row),
    .scrolled    (scrolled),
    .bad_position(bad_position),
    .read_char   (read_char),
    .read_attr   (read_attr)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Writes outside the store are dropped, as tab spaces past the end are.
  function automatic void shadow_write(input int unsigned idx, input logic [BYTE_W-1:0] ch,
                                       input logic [BYTE_W-1:0] at);
    if (idx < NCELLS) begin
      shadow_cells[idx] = {at, ch};
    end
  endfunction

  // Puts one character at cell pos and returns the new cursor, scrolling when it runs off.
  function automatic int unsigned shadow_putc(input int unsigned pos,
                                              input logic [BYTE_W-1:0] ch,
                                              input logic [BYTE_W-1:0] at,
                                              output logic scr);
    logic [BYTE_W-1:0] eff_at;
    eff_at = (at == '0) ? shadow_dflt : at;
    scr = 1'b0;
    case (ch)
      CH_NEWLINE: pos = (pos / COLS + 1) * COLS;
      CH_RETURN:  pos = (pos / COLS) * COLS;
      CH_TAB: begin
        for (int k = 0; k < TAB_SPACES; k++) begin
          shadow_write(pos, CH_SPACE, eff_at);
          pos++;
        end
      end
      default: begin
        shadow_write(pos, ch, eff_at);
        pos++;
      end
    endcase
    if (pos >= NCELLS) begin
      for (int i = 0; i < NCELLS - COLS; i++) begin
        shadow_cells[i] = shadow_cells[i + COLS];
      end
      for (int i = NCELLS - COLS; i < NCELLS; i++) begin
        shadow_cells[i] = '0;
      end
      pos -= COLS;
      scr = 1'b1;
    end
    return pos;
  endfunction

  // Carries out one command on the mirror and returns the status the block should report.
  function automatic status_t console_predict(input logic [CMD_W-1:0] cmd,
                                              input logic [BYTE_W-1:0] ch,
                                              input logic [BYTE_W-1:0] at,
                                              input logic [COL_W-1:0] c,
                                              input logic [ROW_W-1:0] r);
    status_t st;
    logic    off_screen;
    logic    scr_hit;
    st = '0;
    scr_hit = 1'b0;
    off_screen = (c >= COLS) || (r >= ROWS);
    case (cmd)
      CMD_PUT_CURSOR: shadow_cursor = shadow_putc(shadow_cursor, ch, at, scr_hit);
      CMD_PUT_POS: begin
        st.bad = off_screen;
        if (off_screen) begin
          shadow_write(NCELLS - 1, CH_ERROR, shadow_err);
        end else begin
          shadow_cursor = shadow_putc(r * COLS + c, ch, at, scr_hit);
        end
      end
      CMD_BACKSPACE: begin
        if (shadow_cursor > 0) begin
          shadow_cursor--;
        end
        shadow_write(shadow_cursor, CH_SPACE, shadow_dflt);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) begin
          shadow_cells[i] = {shadow_dflt, CH_SPACE};
        end
        shadow_cursor = 0;
      end
      CMD_READ: begin
        st.bad = off_screen;
        if (!off_screen) begin
          {st.rd_attr, st.rd_char} = shadow_cells[r * COLS + c];
        end
      end
      default: ;
    endcase
    st.scr     = scr_hit;
    st.cur_col = COL_W'(shadow_cursor % COLS);
    st.cur_row = ROW_W'(shadow_cursor / COLS);
    return st;
  endfunction

  // Mostly printable text, with a fair share of control codes and raw bytes.
  function automatic logic [BYTE_W-1:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return BYTE_W'($urandom_range(32, 126));
    if (sel < 80) return CH_NEWLINE;
    if (sel < 85) return CH_RETURN;
    if (sel < 92) return CH_TAB;
    return BYTE_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_REPORTS) begin
      $display("mismatch at result %0d: %s is %0d, expected %0d", result_count, what, got, want);
    end
    err_count++;
  endtask

  // Offers one item in bursts with random gaps and records its expected status on acceptance.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] ch,
                           input logic [BYTE_W-1:0] at, input logic [COL_W-1:0] c,
                           input logic [ROW_W-1:0] r, input logic typed, input status_t want);
    status_t st;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
    end
    burst_left--;
    command   <= cmd;
    char_code <= ch;
    attr      <= at;
    col       <= c;
    row       <= r;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    st = console_predict(cmd, ch, at, c, r);
    pending_status.push_back(typed ? want : st);
  endtask

  // Random item: irrelevant fields stay fully random, the rest is shaped per command.
  task automatic send_random();
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] at;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    int                pick;
    int                near;
    ch   = BYTE_W'($urandom);
    at   = BYTE_W'($urandom);
    c    = COL_W'($urandom);
    r    = ROW_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      cmd = CMD_PUT_CURSOR;
      ch  = pick_char();
      if ($urandom_range(0, 3) == 0) at = '0;
    end else if (pick < 57) begin
      cmd = CMD_PUT_POS;
      ch  = pick_char();
      if ($urandom_range(0, 3) == 0) at = '0;
      if ($urandom_range(0, 6) != 0) begin
        c = COL_W'($urandom_range(0, COLS - 1));
        r = ($urandom_range(0, 4) == 0) ? ROW_W'(ROWS - 1) : ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 65) begin
      cmd = CMD_BACKSPACE;
    end else if (pick < 66) begin
      cmd = CMD_CLEAR;
    end else if (pick < 98) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 1) == 0) begin
        // Read just behind the cursor, where the latest writes landed.
        near = int'(shadow_cursor) - $urandom_range(0, 8);
        if (near < 0) near = 0;
        c = COL_W'(near % COLS);
        r = ROW_W'(near / COLS);
      end else if ($urandom_range(0, 4) != 0) begin
        c = COL_W'($urandom_range(0, COLS - 1));
        r = ROW_W'($urandom_range(0, ROWS - 1));
      end
    end else begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    send_item(cmd, ch, at, c, r, 1'b0, '0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_DEFAULT_ATTR: shadow_dflt = data;
      CFG_ERROR_ATTR:   shadow_err  = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits for every expected status to come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result check against the oldest expectation, and the receiver's stall pattern.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with nothing pending, cursor_col", cursor_col, 0);
      end else begin
        oldest = pending_status.pop_front();
        if (cursor_col !== oldest.cur_col) report_mismatch("cursor_col", cursor_col, oldest.cur_col);
        if (cursor_row !== oldest.cur_row) report_mismatch("cursor_row", cursor_row, oldest.cur_row);
        if (scrolled !== oldest.scr) report_mismatch("scrolled", scrolled, oldest.scr);
        if (bad_position !== oldest.bad) report_mismatch("bad_position", bad_position, oldest.bad);
        if (read_char !== oldest.rd_char) report_mismatch("read_char", read_char, oldest.rd_char);
        if (read_attr !== oldest.rd_attr) report_mismatch("read_attr", read_attr, oldest.rd_attr);
      end
      result_count++;
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
      default:        out_stall <= ((stall_tick % 40) < 25);
    endcase
  end

  // Main sequence: reset, directed table, then random phases under changing attributes.
  initial begin
    for (int i = 0; i < NCELLS; i++) begin
      shadow_cells[i] = '0;
    end
    shadow_cursor = 0;
    shadow_dflt   = DEFAULT_ATTR_RST;
    shadow_err    = ERROR_ATTR_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      send_item(DIR_TABLE[i].cmd, DIR_TABLE[i].ch, DIR_TABLE[i].at, DIR_TABLE[i].c,
                DIR_TABLE[i].r, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          cfg_write(CFG_DEFAULT_ATTR, 8'h00);
          cfg_write(CFG_ERROR_ATTR, 8'hFF);
        end
        1: begin
          cfg_write(CFG_DEFAULT_ATTR, 8'hFF);
          cfg_write(CFG_ERROR_ATTR, 8'h00);
        end
        2: begin
          cfg_write(CFG_DEFAULT_ATTR, BYTE_W'($urandom));
          cfg_write(CFG_ERROR_ATTR, BYTE_W'($urandom));
          // Spare indexes must leave both registers alone.
          cfg_write(CFG_SPARE_LO, BYTE_W'($urandom));
          cfg_write(CFG_SPARE_HI, BYTE_W'($urandom));
        end
        default: begin
          cfg_write(CFG_DEFAULT_ATTR, BYTE_W'($urandom));
          cfg_write(CFG_ERROR_ATTR, BYTE_W'($urandom));
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit well beyond a run in which every item scrolls and waits out long stalls.
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
